>>> hw/rtl/fcknn_pkg.sv
// ----------------------------------------------------------------------------
// fcknn_pkg
// Shared constants, codes and types of the code table nearest-entry search.
// ----------------------------------------------------------------------------
`default_nettype none

package fcknn_pkg;

   localparam int MAX_ENTRIES     = 256;
   localparam int MAX_CODE_LENGTH = 512;
   localparam int FRAGMENT_DIM    = 16;
   localparam int MAX_NEIGHBOURS  = 8;

   localparam int ENTRY_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int POS_W   = $clog2(MAX_CODE_LENGTH);
   localparam int LEN_W   = $clog2(MAX_CODE_LENGTH + 1);
   localparam int FRAG_W  = $clog2(FRAGMENT_DIM);
   localparam int LANE_W  = FRAG_W + 1;
   localparam int ROW_W   = MAX_ENTRIES * LANE_W;
   localparam int K_W     = $clog2(MAX_NEIGHBOURS + 1);
   localparam int KIDX_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_CODE_LENGTH = 1'b0;
   localparam logic REG_NEIGHBOURS  = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_FULL   = 2'd2
   } kind_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // One classified word from the front end.
   typedef struct packed {
      op_type              op;
      logic                first;
      logic                in_range;
      logic                present;
      logic                last;
      logic [POS_W-1:0]    pos;
      logic [FRAG_W-1:0]   frag;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/fcknn_front.sv
// ----------------------------------------------------------------------------
// fcknn_front
// Accepts fragment words, tracks the position in the code and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module fcknn_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [fcknn_pkg::LEN_W-1:0] eff_len,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_func,
   input  wire logic signed [4:0]           req_fragment,
   input  wire logic                        req_last,
   output logic                             push,
   output fcknn_pkg::cmd_type               push_cmd,
   input  wire logic                        queue_full
);
   import fcknn_pkg::*;

   logic [LEN_W-1:0] pos_ff, pos_in;
   op_type           op_ff, op_in;
   logic             first;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign first     = (pos_ff == '0);

   always_comb begin
      push_cmd.op       = first ? op_type'(req_func) : op_ff;
      push_cmd.first    = first;
      push_cmd.in_range = (pos_ff < eff_len);
      push_cmd.present  = (req_fragment >= 0) && (int'(req_fragment) < FRAGMENT_DIM);
      push_cmd.last     = req_last;
      push_cmd.pos      = pos_ff[POS_W-1:0];
      push_cmd.frag     = req_fragment[FRAG_W-1:0];
   end

   always_comb begin
      pos_in = pos_ff;
      op_in  = op_ff;
      if (push) begin
         op_in = push_cmd.op;
         if (req_last) begin
            pos_in = '0;
         end else if (pos_ff < LEN_W'(MAX_CODE_LENGTH)) begin
            pos_in = pos_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         op_ff  <= OP_ADD;
      end else begin
         pos_ff <= pos_in;
         op_ff  <= op_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fcknn_queue.sv
// ----------------------------------------------------------------------------
// fcknn_queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcknn_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fcknn_pkg::cmd_type push_cmd,
   output logic                    full,
   output logic                    pop_valid,
   output fcknn_pkg::cmd_type      pop_cmd,
   input  wire logic               pop
);
   import fcknn_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && pop_valid)) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (!push && pop && pop_valid) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PTR_W'(1);
         end
         if (pop && pop_valid) begin
            rd_ff <= rd_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fcknn_back.sv
// ----------------------------------------------------------------------------
// fcknn_back
// Code table, per-entry match counters, ranking scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcknn_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [fcknn_pkg::LEN_W-1:0] eff_len,
   input  wire logic [fcknn_pkg::K_W-1:0]   eff_k,
   input  wire logic                        cmd_valid,
   input  wire fcknn_pkg::cmd_type          cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic signed [8:0]                rsp_entry_id,
   output logic [9:0]                       rsp_mismatches,
   output logic [3:0]                       rsp_found_count,
   output logic                             rsp_last_result
);
   import fcknn_pkg::*;

   typedef enum logic [1:0] {S_TAKE, S_CMP, S_SCAN, S_EMIT} state_type;

   // Table memory: one row per position, one lane per entry.
   logic [ROW_W-1:0]   mem [MAX_CODE_LENGTH];
   logic [ROW_W-1:0]   row_ff;

   state_type          state_ff;
   logic [LEN_W-1:0]   cnt_ff   [MAX_ENTRIES];
   logic [LEN_W-1:0]   slen_ff  [MAX_ENTRIES];
   logic [CNT_W-1:0]   entries_ff;
   logic [LEN_W-1:0]   add_len_ff;
   logic [POS_W-1:0]   cmp_pos_ff;
   logic [FRAG_W-1:0]  cmp_frag_ff;
   logic               cmp_last_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [K_W-1:0]     found_ff;
   logic [K_W-1:0]     rank_ff;
   logic [LEN_W-1:0]   score_ff [MAX_NEIGHBOURS];
   logic [ENTRY_W-1:0] bid_ff   [MAX_NEIGHBOURS];

   logic               rsp_valid_ff;
   kind_type           kind_ff;
   logic [8:0]         id_ff;
   logic [LEN_W-1:0]   mis_ff;
   logic [K_W-1:0]     fcnt_ff;
   logic               lastr_ff;

   logic               out_free;
   logic               full;
   logic               take;
   logic               wr_en;
   logic               rd_en;
   logic [LEN_W-1:0]   len_now;
   logic [LEN_W-1:0]   score_now;
   logic [K_W-1:0]     ins_at;
   logic               ins;
   logic [KIDX_W-1:0]  rank_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (entries_ff == CNT_W'(MAX_ENTRIES));
   assign cmd_pop  = (state_ff == S_TAKE) && cmd_valid &&
                     !(cmd.op == OP_ADD && cmd.last && !out_free);
   assign take     = cmd_pop;
   assign wr_en    = take && cmd.op == OP_ADD && cmd.in_range && !full;
   assign rd_en    = take && cmd.op == OP_QUERY && cmd.in_range && cmd.present;
   assign rank_idx = rank_ff[KIDX_W-1:0];

   always_comb begin
      if (cmd.in_range) begin
         len_now = LEN_W'(cmd.pos) + LEN_W'(1);
      end else if (cmd.first) begin
         len_now = '0;
      end else begin
         len_now = add_len_ff;
      end
   end

   // Insertion point of the entry at the head of the scan.
   always_comb begin
      score_now = eff_len - ((cnt_ff[0] > eff_len) ? eff_len : cnt_ff[0]);
      ins_at    = '0;
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         if ((K_W'(j) < found_ff) && (score_ff[j] < score_now)) begin
            ins_at = ins_at + K_W'(1);
         end
      end
      ins = (ins_at < eff_k);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.pos][entries_ff[ENTRY_W-1:0]*LANE_W +: LANE_W] <= {cmd.present, cmd.frag};
      end
      if (rd_en) begin
         row_ff <= mem[cmd.pos];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmp_pos_ff  <= cmd.pos;
         cmp_frag_ff <= cmd.frag;
         cmp_last_ff <= cmd.last;
         if (cmd.op == OP_ADD) begin
            add_len_ff <= len_now;
            if (cmd.last && !full) begin
               slen_ff[entries_ff[ENTRY_W-1:0]] <= len_now;
            end
         end
      end
      if (state_ff == S_SCAN && ins) begin
         for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
            if (K_W'(j) == ins_at) begin
               score_ff[j] <= score_now;
               bid_ff[j]   <= idx_ff[ENTRY_W-1:0];
            end else if (K_W'(j) > ins_at) begin
               score_ff[j] <= score_ff[(j + MAX_NEIGHBOURS - 1) % MAX_NEIGHBOURS];
               bid_ff[j]   <= bid_ff[(j + MAX_NEIGHBOURS - 1) % MAX_NEIGHBOURS];
            end
         end
      end
      // Match counters: cleared at query start, bumped per lane, shifted by the scan.
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (take && cmd.op == OP_QUERY && cmd.first) begin
            cnt_ff[i] <= '0;
         end else if (state_ff == S_CMP) begin
            if ((CNT_W'(i) < entries_ff) && (LEN_W'(cmp_pos_ff) < slen_ff[i]) &&
                (row_ff[i*LANE_W +: LANE_W] == {1'b1, cmp_frag_ff})) begin
               cnt_ff[i] <= cnt_ff[i] + LEN_W'(1);
            end
         end else if (state_ff == S_SCAN) begin
            cnt_ff[i] <= (i + 1 < MAX_ENTRIES) ? cnt_ff[(i + 1) % MAX_ENTRIES] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         entries_ff   <= '0;
         idx_ff       <= '0;
         found_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_ADD;
         id_ff        <= '0;
         mis_ff       <= '0;
         fcnt_ff      <= '0;
         lastr_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_TAKE: begin
               if (take) begin
                  idx_ff   <= '0;
                  found_ff <= '0;
                  rank_ff  <= '0;
                  if (cmd.op == OP_ADD) begin
                     if (cmd.last) begin
                        rsp_valid_ff <= 1'b1;
                        mis_ff       <= '0;
                        fcnt_ff      <= '0;
                        lastr_ff     <= 1'b1;
                        if (full) begin
                           kind_ff <= KIND_FULL;
                           id_ff   <= '1;
                        end else begin
                           kind_ff    <= KIND_ADD;
                           id_ff      <= 9'(entries_ff);
                           entries_ff <= entries_ff + CNT_W'(1);
                        end
                     end
                  end else if (rd_en) begin
                     state_ff <= S_CMP;
                  end else if (cmd.last) begin
                     state_ff <= (entries_ff == '0) ? S_EMIT : S_SCAN;
                  end
               end
            end
            S_CMP: begin
               if (cmp_last_ff) begin
                  state_ff <= (entries_ff == '0) ? S_EMIT : S_SCAN;
               end else begin
                  state_ff <= S_TAKE;
               end
            end
            S_SCAN: begin
               if (ins && found_ff < eff_k) begin
                  found_ff <= found_ff + K_W'(1);
               end
               idx_ff <= idx_ff + CNT_W'(1);
               if (idx_ff + CNT_W'(1) == entries_ff) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  kind_ff      <= KIND_REPORT;
                  fcnt_ff      <= found_ff;
                  lastr_ff     <= (rank_ff + K_W'(1) == eff_k);
                  if (rank_ff < found_ff) begin
                     id_ff  <= {1'b0, bid_ff[rank_idx]};
                     mis_ff <= score_ff[rank_idx];
                  end else begin
                     id_ff  <= '1;
                     mis_ff <= eff_len;
                  end
                  rank_ff <= rank_ff + K_W'(1);
                  if (rank_ff + K_W'(1) == eff_k) begin
                     state_ff <= S_TAKE;
                  end
               end
            end
            default: state_ff <= S_TAKE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_entry_id    = id_ff;
   assign rsp_mismatches  = mis_ff;
   assign rsp_found_count = fcnt_ff;
   assign rsp_last_result = lastr_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fern_code_knn_database_core.sv
// ----------------------------------------------------------------------------
// fern_code_knn_database_core
// Stores compact fragment codes and reports the stored codes nearest a query.
// ----------------------------------------------------------------------------
// A code arrives as a run of words, one fragment per word, with the function
// (add or query) taken from the first word and the run closed by last. An add
// stores the code as a new entry and returns its id, or reports the table full;
// a query returns the configured number of nearest entries, best first, ranked
// by mismatch count with later ids winning ties. The table memory holds one row
// per code position with one lane per entry, so every stored entry is compared
// against a query fragment at once. In the back end, a query word whose
// fragment is present and inside the code length goes through a memory read
// and then a compare and count; add words and other query words are handled
// as they are taken. At the end of a query the back end ranks the stored
// entries in a scan (skipped when the table is empty), then reports the
// neighbours one by one, holding while the result register is stalled. A
// four-word queue separates the input side from the back end, and a result
// register separates the back end from the output side. The table needs no
// clearing pass after reset. Configuration is written through the csr_ port:
// code_length at byte address 0 and neighbours at byte address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module fern_code_knn_database_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_func,
   input  wire logic signed [4:0]                     req_fragment,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [1:0]                                 rsp_kind,
   output logic signed [8:0]                          rsp_entry_id,
   output logic [9:0]                                 rsp_mismatches,
   output logic [3:0]                                 rsp_found_count,
   output logic                                       rsp_last_result,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [fcknn_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [fcknn_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fcknn_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                       csr_pready
);
   import fcknn_pkg::*;

   logic [9:0]       code_length_ff;
   logic [3:0]       neighbours_ff;
   logic [LEN_W-1:0] eff_len;
   logic [K_W-1:0]   eff_k;
   logic             csr_write;
   logic             push;
   cmd_type          push_cmd;
   logic             queue_full;
   logic             pop_valid;
   cmd_type          pop_cmd;
   logic             pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= 10'd512;
         neighbours_ff  <= 4'd4;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_CODE_LENGTH: code_length_ff <= csr_pwdata[9:0];
            REG_NEIGHBOURS:  neighbours_ff  <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CODE_LENGTH: csr_prdata = CSR_DATA_W'(code_length_ff);
         REG_NEIGHBOURS:  csr_prdata = CSR_DATA_W'(neighbours_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Out-of-range register values are clamped into the supported range.
   always_comb begin
      if (code_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(code_length_ff) > MAX_CODE_LENGTH) begin
         eff_len = LEN_W'(MAX_CODE_LENGTH);
      end else begin
         eff_len = LEN_W'(code_length_ff);
      end
      if (neighbours_ff == '0) begin
         eff_k = K_W'(1);
      end else if (32'(neighbours_ff) > MAX_NEIGHBOURS) begin
         eff_k = K_W'(MAX_NEIGHBOURS);
      end else begin
         eff_k = K_W'(neighbours_ff);
      end
   end

   fcknn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .eff_len      (eff_len),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_fragment (req_fragment),
      .req_last     (req_last),
      .push         (push),
      .push_cmd     (push_cmd),
      .queue_full   (queue_full)
   );

   fcknn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop)
   );

   fcknn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .eff_len         (eff_len),
      .eff_k           (eff_k),
      .cmd_valid       (pop_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_mismatches  (rsp_mismatches),
      .rsp_found_count (rsp_found_count),
      .rsp_last_result (rsp_last_result)
   );

endmodule

`default_nettype wire
